// ===== rtl/shared_counter_reservation_unit_assert.svh =====
// Assertion macros shared by the counter reservation unit.
`ifndef SHARED_COUNTER_RESERVATION_UNIT_ASSERT_SVH
`define SHARED_COUNTER_RESERVATION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and quiet during reset.
`define SCRU_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("counter reservation check failed");

// Next-cycle implication, sampled on clk_i and quiet during reset.
`define SCRU_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("counter reservation check failed");

`endif

// ===== rtl/scru_pkg.sv =====
// Package of types, codes and constants for the counter reservation unit.
package scru_pkg;

  // Ceiling on the number of counters that one group can hold.
  localparam int COUNTER_CEILING = 32;

  // Default geometry of the counter store.
  localparam int GROUP_COUNT_DEF      = 8;
  localparam int SLOTS_PER_GROUP_DEF  = COUNTER_CEILING;

  // Field widths of the request and result transfers.
  localparam int FUNC_W   = 1;
  localparam int GROUP_W  = 3;
  localparam int KIND_W   = 10;
  localparam int SLOT_W   = 5;
  localparam int LIMIT_W  = 6;
  localparam int STATUS_W = 3;
  localparam int USERS_W  = 8;
  localparam int HW_W     = 6;

  // Request codes.
  localparam logic [FUNC_W-1:0] FUNC_RESERVE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

  // Saturation value of a user count.
  localparam logic [USERS_W-1:0] USERS_MAX = 8'hFF;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_SHARED       = 3'd0,
    ST_NEW          = 3'd1,
    ST_NONE         = 3'd2,
    ST_FREED        = 3'd3,
    ST_STILL_USED   = 3'd4,
    ST_NOT_ASSIGNED = 3'd5
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic read;
    logic scan;
    logic commit;
  } dp_cmd_t;

endpackage

// ===== rtl/scru_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module scru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/scru_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
module scru_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output scru_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   commit;

  // Commands follow the state; the commit waits for a free output register.
  assign accept = in_valid_i && (state_q == S_IDLE);
  assign commit = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.latch  = accept;
    cmd_o.read   = (state_q == S_READ);
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.commit = commit;
  end

  // Next state and result valid.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ:   state_d = S_SCAN;
      S_SCAN:   state_d = S_COMMIT;
      S_COMMIT: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase

    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/scru_dp.sv =====
// Datapath: busy maps, high-water marks, row memories, slot search and result register.
module scru_dp #(
  parameter int GROUP_COUNT     = scru_pkg::GROUP_COUNT_DEF,
  parameter int SLOTS_PER_GROUP = scru_pkg::SLOTS_PER_GROUP_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  scru_pkg::dp_cmd_t              cmd_i,
  input  logic [scru_pkg::FUNC_W-1:0]    func_i,
  input  logic [scru_pkg::GROUP_W-1:0]   group_index_i,
  input  logic [scru_pkg::KIND_W-1:0]    event_kind_i,
  input  logic [scru_pkg::SLOT_W-1:0]    slot_to_free_i,
  input  logic [scru_pkg::LIMIT_W-1:0]   group_slot_limit_i,
  output logic [scru_pkg::STATUS_W-1:0]  status_o,
  output logic [scru_pkg::SLOT_W-1:0]    slot_number_o,
  output logic [scru_pkg::USERS_W-1:0]   users_now_o,
  output logic [scru_pkg::HW_W-1:0]      high_water_o,
  output logic                           high_water_changed_o
);

  localparam int GA_W  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int SI_W  = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
  localparam int MK_W  = $clog2(SLOTS_PER_GROUP + 1);
  localparam int KW    = scru_pkg::KIND_W;
  localparam int UW    = scru_pkg::USERS_W;
  localparam int EV_RW = SLOTS_PER_GROUP * KW;
  localparam int US_RW = SLOTS_PER_GROUP * UW;

  // Request register.
  logic [scru_pkg::FUNC_W-1:0]  func_q;
  logic [scru_pkg::GROUP_W-1:0] grp_q;
  logic [KW-1:0]                kind_q;
  logic [scru_pkg::SLOT_W-1:0]  rel_q;
  logic [scru_pkg::LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q  <= func_i;
      grp_q   <= group_index_i;
      kind_q  <= event_kind_i;
      rel_q   <= slot_to_free_i;
      limit_q <= group_slot_limit_i;
    end
  end

  // Group selection.
  logic [GA_W-1:0]            ga;
  logic                       grp_ok;
  logic [SLOTS_PER_GROUP-1:0] busy_q [GROUP_COUNT];
  logic [MK_W-1:0]            hw_q [GROUP_COUNT];
  logic [SLOTS_PER_GROUP-1:0] busy_row;
  logic [MK_W-1:0]            hw_cur;

  assign ga       = GA_W'(grp_q);
  assign grp_ok   = (32'(grp_q) < GROUP_COUNT);
  assign busy_row = grp_ok ? busy_q[ga] : '0;
  assign hw_cur   = grp_ok ? hw_q[ga] : '0;

  // Row memories: one row holds the event kinds or user counts of a whole group.
  logic             ev_we, us_we;
  logic [EV_RW-1:0] ev_rdata, ev_wdata;
  logic [US_RW-1:0] us_rdata, us_wdata;

  scru_ram #(
    .WIDTH (EV_RW),
    .DEPTH (GROUP_COUNT)
  ) u_ev_ram (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (ga),
    .wdata_i (ev_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (ga),
    .rdata_o (ev_rdata)
  );

  scru_ram #(
    .WIDTH (US_RW),
    .DEPTH (GROUP_COUNT)
  ) u_us_ram (
    .clk_i   (clk_i),
    .we_i    (us_we),
    .waddr_i (ga),
    .wdata_i (us_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (ga),
    .rdata_o (us_rdata)
  );

  // Slot search: kind match among busy slots and lowest free slot below the limit.
  logic [SLOTS_PER_GROUP-1:0] match_vec, free_vec;
  logic [SI_W-1:0]            hit_idx, free_idx, rel_idx;
  logic                       rel_ok;

  assign rel_idx = SI_W'(rel_q);
  assign rel_ok  = (32'(rel_q) < SLOTS_PER_GROUP) && busy_row[rel_idx];

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
      match_vec[s] = busy_row[s] && (ev_rdata[s*KW +: KW] == kind_q);
      free_vec[s]  = !busy_row[s] && (s < 32'(limit_q));
    end
    for (int s = SLOTS_PER_GROUP - 1; s >= 0; s--) begin
      if (match_vec[s]) begin
        hit_idx = SI_W'(s);
      end
      if (free_vec[s]) begin
        free_idx = SI_W'(s);
      end
    end
  end

  logic            hit_q, free_q, rel_ok_q;
  logic [SI_W-1:0] hit_idx_q, free_idx_q;
  logic [UW-1:0]   hit_users_q, rel_users_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      hit_q       <= |match_vec;
      free_q      <= |free_vec;
      rel_ok_q    <= rel_ok;
      hit_idx_q   <= hit_idx;
      free_idx_q  <= free_idx;
      hit_users_q <= us_rdata[hit_idx*UW +: UW];
      rel_users_q <= us_rdata[rel_idx*UW +: UW];
    end
  end

  // Commit: decide the outcome, update the maps and rewrite the touched rows.
  scru_pkg::status_e          st;
  logic [SI_W-1:0]            slot_idx, us_idx;
  logic [scru_pkg::SLOT_W-1:0] slot_out;
  logic [UW-1:0]              users_out, us_val;
  logic [SLOTS_PER_GROUP-1:0] new_busy;
  logic                       busy_we;
  logic [MK_W-1:0]            new_mark, hw_out;
  logic                       chg;

  always_comb begin
    st        = scru_pkg::ST_NONE;
    slot_idx  = '0;
    slot_out  = '0;
    users_out = '0;
    new_busy  = busy_row;
    busy_we   = 1'b0;
    ev_we     = 1'b0;
    us_we     = 1'b0;
    us_idx    = hit_idx_q;
    us_val    = '0;

    if (!grp_ok) begin
      st = (func_q == scru_pkg::FUNC_RELEASE) ? scru_pkg::ST_NOT_ASSIGNED
                                              : scru_pkg::ST_NONE;
    end else if (func_q == scru_pkg::FUNC_RESERVE) begin
      if (hit_q) begin
        slot_idx = hit_idx_q;
        slot_out = scru_pkg::SLOT_W'(hit_idx_q);
        if (hit_users_q == scru_pkg::USERS_MAX) begin
          st        = scru_pkg::ST_NONE;
          users_out = scru_pkg::USERS_MAX;
        end else begin
          st        = scru_pkg::ST_SHARED;
          users_out = hit_users_q + UW'(1);
          us_we     = cmd_i.commit;
          us_val    = users_out;
        end
      end else if (free_q) begin
        st                 = scru_pkg::ST_NEW;
        slot_idx           = free_idx_q;
        slot_out           = scru_pkg::SLOT_W'(free_idx_q);
        users_out          = UW'(1);
        new_busy[free_idx_q] = 1'b1;
        busy_we            = 1'b1;
        ev_we              = cmd_i.commit;
        us_we              = cmd_i.commit;
        us_idx             = free_idx_q;
        us_val             = UW'(1);
      end
    end else begin
      slot_idx = rel_idx;
      slot_out = rel_q;
      us_idx   = rel_idx;
      if (!rel_ok_q) begin
        st = scru_pkg::ST_NOT_ASSIGNED;
      end else if (rel_users_q <= UW'(1)) begin
        st                = scru_pkg::ST_FREED;
        new_busy[rel_idx] = 1'b0;
        busy_we           = 1'b1;
        us_we             = cmd_i.commit;
        us_val            = '0;
      end else begin
        st        = scru_pkg::ST_STILL_USED;
        users_out = rel_users_q - UW'(1);
        us_we     = cmd_i.commit;
        us_val    = users_out;
      end
    end
  end

  // High-water mark of the updated busy map.
  always_comb begin
    new_mark = '0;
    for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
      if (new_busy[s]) begin
        new_mark = MK_W'(s + 1);
      end
    end
    hw_out = busy_we ? new_mark : hw_cur;
    chg    = busy_we && (new_mark != hw_cur);
  end

  // Row rewrite data: the held read row with one field replaced.
  always_comb begin
    ev_wdata = ev_rdata;
    us_wdata = us_rdata;
    ev_wdata[slot_idx*KW +: KW] = kind_q;
    us_wdata[us_idx*UW +: UW]   = us_val;
  end

  // Busy maps and high-water marks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '{default: '0};
      hw_q   <= '{default: '0};
    end else if (cmd_i.commit && busy_we) begin
      busy_q[ga] <= new_busy;
      hw_q[ga]   <= new_mark;
    end
  end

  // Result register.
  logic [scru_pkg::STATUS_W-1:0] status_q;
  logic [scru_pkg::SLOT_W-1:0]   slot_q;
  logic [UW-1:0]                 users_q;
  logic [scru_pkg::HW_W-1:0]     hw_res_q;
  logic                          chg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= st;
      slot_q   <= slot_out;
      users_q  <= users_out;
      hw_res_q <= scru_pkg::HW_W'(hw_out);
      chg_q    <= chg;
    end
  end

  assign status_o             = status_q;
  assign slot_number_o        = slot_q;
  assign users_now_o          = users_q;
  assign high_water_o         = hw_res_q;
  assign high_water_changed_o = chg_q;

endmodule

// ===== rtl/shared_counter_reservation_unit.sv =====
// Top level of the shared counter reservation unit.
// Each request passes from transfer in to result in steps: taking the
// transfer, reading the group's row of event kinds and user counts from
// the row memories, searching the row for a matching kind and the lowest
// free counter, and committing, which rewrites the touched row and loads
// the result register. Because of the read-modify-write of those row memories,
// a new request is taken only once the current one has committed, and a result
// still waiting holds the commit and with it the next request transfer.
// Busy maps and high-water marks sit in flip-flops cleared by reset, and the
// busy bits mark which memory entries hold data, so no clearing pass is run.
module shared_counter_reservation_unit #(
  parameter int GROUP_COUNT     = scru_pkg::GROUP_COUNT_DEF,
  parameter int SLOTS_PER_GROUP = scru_pkg::SLOTS_PER_GROUP_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [scru_pkg::FUNC_W-1:0]    func_i,
  input  logic [scru_pkg::GROUP_W-1:0]   group_index_i,
  input  logic [scru_pkg::KIND_W-1:0]    event_kind_i,
  input  logic [scru_pkg::SLOT_W-1:0]    slot_to_free_i,
  input  logic [scru_pkg::LIMIT_W-1:0]   group_slot_limit_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [scru_pkg::STATUS_W-1:0]  status_o,
  output logic [scru_pkg::SLOT_W-1:0]    slot_number_o,
  output logic [scru_pkg::USERS_W-1:0]   users_now_o,
  output logic [scru_pkg::HW_W-1:0]      high_water_o,
  output logic                           high_water_changed_o
);

  scru_pkg::dp_cmd_t cmd;

  // Sequencing.
  scru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Storage, search and result.
  scru_dp #(
    .GROUP_COUNT     (GROUP_COUNT),
    .SLOTS_PER_GROUP (SLOTS_PER_GROUP)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .func_i               (func_i),
    .group_index_i        (group_index_i),
    .event_kind_i         (event_kind_i),
    .slot_to_free_i       (slot_to_free_i),
    .group_slot_limit_i   (group_slot_limit_i),
    .status_o             (status_o),
    .slot_number_o        (slot_number_o),
    .users_now_o          (users_now_o),
    .high_water_o         (high_water_o),
    .high_water_changed_o (high_water_changed_o)
  );

  // Classes of the result on offer, watched by the checks below.
  logic res_new, res_empty, res_steady;

  assign res_new    = out_valid_o && (status_o == scru_pkg::ST_NEW);
  assign res_empty  = out_valid_o &&
                      (status_o inside {scru_pkg::ST_FREED, scru_pkg::ST_NOT_ASSIGNED});
  assign res_steady = out_valid_o &&
                      (status_o inside {scru_pkg::ST_SHARED, scru_pkg::ST_STILL_USED,
                                        scru_pkg::ST_NONE});

  `include "shared_counter_reservation_unit_assert.svh"

  // A request stays in work after its transfer, so no transfer follows at once.
  `SCRU_ASSERT_NEXT(a_no_back_to_back, in_valid_i && in_ready_o, !in_ready_o)
  // A newly assigned counter always has exactly one user.
  `SCRU_ASSERT_IMPL(a_new_one_user, res_new, users_now_o == scru_pkg::USERS_W'(1))
  // Freed or unassigned counters report no users.
  `SCRU_ASSERT_IMPL(a_free_no_users, res_empty, users_now_o == '0)
  // Only a change of the busy map may move the high-water mark.
  `SCRU_ASSERT_IMPL(a_mark_steady, res_steady, !high_water_changed_o)

endmodule
